@@ hdl/adl_pkg.sv @@
// Shared types, constants and modular helpers for the Adler-32 multibyte core.
// No dependencies; used by every module under hdl/.
package adl_pkg;

    // Stream bytes handled per item, and the width of the input data word
    localparam int LANES      = 8;
    localparam int DATA_LANES = 8;
    localparam int EXT_LANES  = (LANES > DATA_LANES) ? LANES : DATA_LANES;

    // Adler-32 base
    localparam logic [15:0] ADLER_MOD = 16'd65521;
    // 2^16 mod base, used to fold the high part of a wide sum
    localparam logic [4:0]  FOLD_K    = 5'd15;

    // Widths of the per-item partial sums
    localparam int N_W   = $clog2(LANES + 1);
    localparam int S_W   = $clog2(LANES * 255 + 1);
    localparam int W_W   = $clog2((LANES * (LANES + 1) / 2) * 255 + 1);
    localparam int ACC_W = 17 + N_W;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified item
    typedef struct packed {
        logic [N_W-1:0] cnt;      // saturated byte count
        logic [S_W-1:0] bsum;     // plain sum of valid bytes
        logic [W_W-1:0] wsum;     // sum of (cnt - i) * byte_i
        logic           first;
        logic [15:0]    seed_lo;  // reduced seed halves
        logic [15:0]    seed_hi;
        logic           last;
    } adl_item_t;

    // Reduce a value known to be below twice the base
    function automatic logic [15:0] mod_once(input logic [16:0] v);
        logic [16:0] d;
        d = v - {1'b0, ADLER_MOD};
        return (v >= {1'b0, ADLER_MOD}) ? d[15:0] : v[15:0];
    endfunction

endpackage

@@ hdl/adl_front.sv @@
// Front end: accepts input items, saturates the count, masks unused lanes
// and forms the state-independent partial sums. Depends on adl_pkg.
module adl_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          data_bytes,
    input  logic [3:0]           byte_count,
    input  logic                 first,
    input  logic [31:0]          seed,
    input  logic                 last,
    input  logic                 q_full,
    output logic                 push,
    output adl_pkg::adl_item_t   item
);

    localparam int EXT_W = adl_pkg::EXT_LANES * 8;

    // Accept whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Per-item sums over the valid lanes
    always_comb
    begin
        logic [EXT_W-1:0]           data_ext;
        logic [adl_pkg::N_W-1:0]    n;
        logic [adl_pkg::S_W-1:0]    s;
        logic [adl_pkg::W_W-1:0]    w;
        logic [adl_pkg::N_W-1:0]    wgt;
        logic [7:0]                 b;
        data_ext = EXT_W'(data_bytes);
        if (5'(byte_count) > 5'(adl_pkg::LANES))
            n = adl_pkg::N_W'(adl_pkg::LANES);
        else
            n = adl_pkg::N_W'(byte_count);
        s = '0;
        w = '0;
        for (int i = 0; i < adl_pkg::LANES; i++)
        begin
            b   = data_ext[i*8 +: 8];
            wgt = n - adl_pkg::N_W'(i);
            if (adl_pkg::N_W'(i) < n)
            begin
                s = s + adl_pkg::S_W'(b);
                w = w + adl_pkg::W_W'(wgt) * adl_pkg::W_W'(b);
            end
        end
        item.cnt     = n;
        item.bsum    = s;
        item.wsum    = w;
        item.first   = first;
        item.seed_lo = adl_pkg::mod_once({1'b0, seed[15:0]});
        item.seed_hi = adl_pkg::mod_once({1'b0, seed[31:16]});
        item.last    = last;
    end

endmodule

@@ hdl/adl_queue.sv @@
// Two-entry item queue between front and back end.
// Depends on adl_pkg for the item type and depth.
module adl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  adl_pkg::adl_item_t   push_item,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output adl_pkg::adl_item_t   head
);

    adl_pkg::adl_item_t           mem_reg [adl_pkg::QDEPTH];
    logic [adl_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [adl_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [adl_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == adl_pkg::QCNT_W'(adl_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == adl_pkg::QPTR_W'(adl_pkg::QDEPTH - 1)) ? '0
                                                                               : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == adl_pkg::QPTR_W'(adl_pkg::QDEPTH - 1)) ? '0
                                                                               : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= adl_pkg::QCNT_W'(adl_pkg::QDEPTH))
        else $error("queue fill count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule

@@ hdl/adl_back.sv @@
// Back end: folds one classified item into the running sums per cycle while items
// wait and the output is not stalled, and holds the result in an output register. Depends on adl_pkg.
module adl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_not_empty,
    input  adl_pkg::adl_item_t   head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          checksum,
    output logic                 final_res
);

    localparam int ACC_W = adl_pkg::ACC_W;

    logic [15:0]   low_sum_reg, low_sum_next;
    logic [15:0]   high_sum_reg, high_sum_next;
    logic          out_valid_reg;
    logic [31:0]   checksum_reg;
    logic          final_reg;
    logic          fire;

    // Take the head item when the output register is free or draining
    assign fire      = q_not_empty && (!out_valid_reg || out_ready);
    assign pop       = fire;
    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;
    assign final_res = final_reg;

    // low' = low + S, high' = high + n*low + W, both mod base
    always_comb
    begin
        logic [15:0]      base_l;
        logic [15:0]      base_h;
        logic [16:0]      l_acc;
        logic [ACC_W-1:0] h_acc;
        logic [16:0]      h_fold;
        base_l = head.first ? head.seed_lo : low_sum_reg;
        base_h = head.first ? head.seed_hi : high_sum_reg;
        l_acc  = 17'(base_l) + 17'(head.bsum);
        h_acc  = ACC_W'(base_h)
               + ACC_W'(head.cnt) * ACC_W'(base_l)
               + ACC_W'(head.wsum);
        // 2^16 is 15 mod base
        h_fold = 17'(h_acc[15:0])
               + 17'(h_acc[ACC_W-1:16]) * 17'(adl_pkg::FOLD_K);
        low_sum_next  = adl_pkg::mod_once(l_acc);
        high_sum_next = adl_pkg::mod_once(h_fold);
    end

    // Running sums and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_sum_reg   <= 16'd1;
            high_sum_reg  <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                low_sum_reg  <= low_sum_next;
                high_sum_reg <= high_sum_next;
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            checksum_reg <= {high_sum_next, low_sum_next};
            final_reg    <= head.last;
        end
    end

`ifndef SYNTHESIS
    a_low_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        low_sum_reg < adl_pkg::ADLER_MOD)
        else $error("low sum not reduced");
    a_high_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        high_sum_reg < adl_pkg::ADLER_MOD)
        else $error("high sum not reduced");
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_valid_reg && checksum_reg == {high_sum_reg, low_sum_reg}))
        else $error("result register out of step with running sums");
`endif

endmodule

@@ hdl/adlr32_multibyte_checksum_core.sv @@
// Top level of the Adler-32 multibyte checksum core.
// Depends on adl_pkg, adl_front, adl_queue and adl_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | data_bytes, byte_count, first, seed, last
//  output   | out_valid / out_ready| checksum, final_res
//
// One item per cycle sustained while the output is not stalled; an accepted item
// is written into the two-entry queue, then the back end's sum update loads the
// output register from the queue head, which makes the result valid. The
// loop on the running sums in the back end sets the rate. in_ready drops only
// when the queue is full because the output is stalled. Reset sets the sums
// to 1 and 0 and empties queue and output.
module adler32_multibyte_checksum_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_bytes,
    input  logic [3:0]  byte_count,
    input  logic        first,
    input  logic [31:0] seed,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] checksum,
    output logic        final_res
);

    adl_pkg::adl_item_t push_item;
    adl_pkg::adl_item_t head;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_not_empty;

    adl_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_bytes (data_bytes),
        .byte_count (byte_count),
        .first      (first),
        .seed       (seed),
        .last       (last),
        .q_full     (q_full),
        .push       (push),
        .item       (push_item)
    );

    adl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    adl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .checksum    (checksum),
        .final_res   (final_res)
    );

endmodule

@@ verif/adler32_multibyte_checksum_core_tb.sv @@
// Self-checking testbench for adler32_multibyte_checksum_core: directed and random items.
// Needs adl_pkg and the core under hdl/; predicts Adler-32 sums locally.
`timescale 1ns / 1ps

module testbench;

    // Run limit, in clock cycles
    localparam int CYCLE_LIMIT = 200000;
    // Accepted-item count at which the long output stall starts, and its length
    localparam int HOLD_AT     = 700;
    localparam int HOLD_LEN    = 60;
    localparam int MOD_BASE    = int'(adl_pkg::ADLER_MOD);

    // One input item as the sender holds it
    typedef struct {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        first;
        logic [31:0] seed;
        logic        last;
    } chunk_t;

    // One expected result
    typedef struct {
        logic [31:0] sum;
        logic        fin;
    } sum_exp_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [63:0] data_bytes = '0;
    logic [3:0]  byte_count = '0;
    logic        first      = 1'b0;
    logic [31:0] seed       = '0;
    logic        last       = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] checksum;
    logic        final_res;

    chunk_t      chunk_q[$];
    sum_exp_t    pending_sums[$];

    // Predicted running sums
    logic [15:0] sum_lo = 16'd1;
    logic [15:0] sum_hi = 16'd0;

    int          total_items    = 0;
    int          accepted_items = 0;
    int          results_seen   = 0;
    int          mismatches     = 0;
    int          cycles         = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;
    int          n_loads        = 0;
    int          n_over         = 0;
    int          n_zero         = 0;
    int          n_ends         = 0;

    adler32_multibyte_checksum_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_bytes (data_bytes),
        .byte_count (byte_count),
        .first      (first),
        .seed       (seed),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .checksum   (checksum),
        .final_res  (final_res)
    );

    always #1 clk = ~clk;

    // Idle percentages per phase: sender light / receiver heavy, swapped, then none
    function automatic int send_idle_pct(input int n);
        if (n < 300)
            return 17;
        else if (n < 600)
            return 77;
        return 0;
    endfunction

    function automatic int recv_idle_pct(input int n);
        if (n < 300)
            return 77;
        else if (n < 600)
            return 17;
        return 0;
    endfunction

    function automatic logic [15:0] reduce_half(input logic [15:0] v);
        if (int'(v) >= MOD_BASE)
            return 16'(int'(v) - MOD_BASE);
        return v;
    endfunction

    // Advance the predicted sums by one item, give back the running checksum
    task automatic advance_sums(input chunk_t c, output logic [31:0] sum);
        int n;
        int lo;
        int hi;
        int b;
        if (c.first)
        begin
            sum_lo = reduce_half(c.seed[15:0]);
            sum_hi = reduce_half(c.seed[31:16]);
        end
        n  = (int'(c.cnt) > adl_pkg::LANES) ? adl_pkg::LANES : int'(c.cnt);
        lo = int'(sum_lo);
        hi = int'(sum_hi);
        for (int i = 0; i < n; i++)
        begin
            // lanes past the 64-bit word read as zero
            b  = (i < 8) ? int'(c.data[8*i +: 8]) : 0;
            lo = (lo + b) % MOD_BASE;
            hi = (hi + lo) % MOD_BASE;
        end
        sum_lo = 16'(lo);
        sum_hi = 16'(hi);
        sum    = {sum_hi, sum_lo};
    endtask

    task automatic add_chunk(input logic [63:0] d, input logic [3:0] n, input logic f,
                             input logic [31:0] s, input logic l);
        chunk_t c;
        c.data  = d;
        c.cnt   = n;
        c.first = f;
        c.seed  = s;
        c.last  = l;
        chunk_q.push_back(c);
        total_items++;
    endtask

    // Seed halves, biased toward the values around the base
    function automatic logic [15:0] pick_half();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 16'hffff;
        else if (r < 14)
            return 16'hfff0;
        else if (r < 20)
            return 16'hfff1;
        else if (r < 26)
            return 16'h0000;
        return 16'($urandom);
    endfunction

    function automatic logic [3:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 4'd0;
        else if (r < 25)
            return 4'd8;
        else if (r < 35)
            return 4'($urandom_range(15, 9));
        return 4'($urandom_range(8, 1));
    endfunction

    function automatic logic [63:0] pick_data();
        if ($urandom_range(9) == 0)
            return {64{1'b1}};
        return {$urandom, $urandom};
    endfunction

    // Driver: presents queued items, predicts each one on acceptance
    always @(posedge clk)
    begin
        chunk_t      c;
        sum_exp_t    e;
        logic [31:0] s;
        bit          fire;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (fire)
            begin
                c.data  = data_bytes;
                c.cnt   = byte_count;
                c.first = first;
                c.seed  = seed;
                c.last  = last;
                advance_sums(c, s);
                e.sum = s;
                e.fin = c.last;
                pending_sums.push_back(e);
                accepted_items <= accepted_items + 1;
                n_loads += c.first;
                n_ends  += c.last;
                n_over  += (int'(c.cnt) > adl_pkg::LANES);
                n_zero  += (c.cnt == 4'd0);
            end
            if (!in_valid || fire)
            begin
                if (chunk_q.size() != 0 && $urandom_range(99) >= send_idle_pct(accepted_items))
                begin
                    c = chunk_q.pop_front();
                    data_bytes <= c.data;
                    byte_count <= c.cnt;
                    first      <= c.first;
                    seed       <= c.seed;
                    last       <= c.last;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long output stall, once, while the sender keeps offering items
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_items >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Monitor: checks each result against the oldest prediction
    always @(posedge clk)
    begin
        sum_exp_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                // only predictions made at earlier edges count as waiting
                if (results_seen >= accepted_items || pending_sums.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: checksum %08h final_res %0b",
                                 checksum, final_res);
                end
                else
                begin
                    e = pending_sums.pop_front();
                    if (checksum !== e.sum || final_res !== e.fin)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %08h/%0b, got %08h/%0b",
                                     results_seen, e.sum, e.fin, checksum, final_res);
                    end
                end
                results_seen++;
            end
            out_ready <= (hold_left == 0) &&
                         ($urandom_range(99) >= recv_idle_pct(results_seen));
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_sums.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int msg_len;
        // Directed items: counts at the extremes, seed halves around the base
        add_chunk(64'h0, 4'd0, 1'b0, 32'h0, 1'b0);                 // zero count from reset
        add_chunk({64{1'b1}}, 4'd8, 1'b0, 32'h0, 1'b0);
        add_chunk(64'h0, 4'd8, 1'b0, 32'h0, 1'b0);
        add_chunk(64'h0807060504030201, 4'd4, 1'b0, 32'h0, 1'b0);  // byte order
        add_chunk({64{1'b1}}, 4'd15, 1'b0, 32'h0, 1'b0);           // count saturates
        add_chunk(64'h0123456789abcdef, 4'd9, 1'b0, 32'h0, 1'b0);
        add_chunk(64'h0, 4'd0, 1'b1, 32'hffffffff, 1'b0);          // seed halves reduce
        add_chunk({64{1'b1}}, 4'd8, 1'b1, 32'hfff0fff0, 1'b0);     // sums wrap
        add_chunk(64'hff, 4'd1, 1'b1, 32'hfff1fff1, 1'b0);
        add_chunk(64'h0, 4'd0, 1'b1, 32'h0, 1'b1);
        add_chunk(64'h0000000000ffeedd, 4'd3, 1'b0, 32'h0, 1'b1);  // last, then more
        add_chunk(64'haa55aa55aa55aa55, 4'd8, 1'b0, 32'h0, 1'b0);
        add_chunk(64'h55aa55aa55aa55aa, 4'd7, 1'b1, 32'h00010001, 1'b0); // reload mid-message
        add_chunk({64{1'b1}}, 4'd8, 1'b1, 32'h0000ffff, 1'b1);     // first and last together
        add_chunk({64{1'b1}}, 4'd8, 1'b1, 32'hffff0000, 1'b0);
        add_chunk({64{1'b1}}, 4'd12, 1'b0, 32'hffffffff, 1'b0);
        add_chunk(64'h8000000000000001, 4'd8, 1'b0, 32'h0, 1'b1);
        add_chunk(64'h0, 4'd2, 1'b0, 32'h0, 1'b0);

        // Random part: mostly whole messages, some loose items with random flags
        while (total_items < 918)
        begin
            if ($urandom_range(99) < 15)
            begin
                add_chunk(pick_data(), 4'($urandom), 1'($urandom),
                          {pick_half(), pick_half()}, 1'($urandom));
            end
            else
            begin
                msg_len = $urandom_range(12, 1);
                for (int i = 0; i < msg_len; i++)
                    add_chunk(pick_data(), pick_count(), i == 0,
                              (i == 0) ? {pick_half(), pick_half()} : 32'($urandom),
                              i == msg_len - 1);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_items == total_items);
        wait (pending_sums.size() == 0);
        repeat (10) @(posedge clk);

        $display("%0d items checked: %0d seed loads, %0d zero counts, %0d over-range counts",
                 results_seen, n_loads, n_zero, n_over);
        $display("%0d message ends; long output stall taken: %0b; %0d mismatches",
                 n_ends, hold_done, mismatches);
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
